/* design/first_fit_block_allocator_defines.svh */
// Assertion macros for the first-fit block allocator checker.
// No dependencies; included by the checker file only.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba: next-cycle check failed");

`endif

/* design/ffba_pkg.sv */
// Shared constants and controller/datapath interface types for the
// first-fit block allocator. No dependencies.
package ffba_pkg;

    // Default table geometry
    localparam int DEF_NUM_BLOCKS = 32;
    localparam int DEF_SIZE_BITS  = 16;

    // Fixed port field widths
    localparam int COUNT_W      = 6;
    localparam int INDEX_W      = 5;
    localparam int SIZE_FIELD_W = 16;

    // One more than the largest scan a block_count register can ask for
    localparam int MAX_SCAN = 2 ** COUNT_W;

    // Item command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // write a block size and free the block
        logic start;  // capture request and scan limit, rewind pointer
        logic scan;   // issue next table read and advance check stage
        logic grant;  // mark checked block used, load hit result
        logic miss;   // load not-found result
    } t_ffba_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic hit;        // block in check stage is free and large enough
        logic exhausted;  // every block up to the limit has been checked
    } t_ffba_status;

endpackage

/* design/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator; uses ffba_pkg, ffba_ctrl, ffba_datapath.
// Load beat: writes a block size and frees the block, no result. Allocate beat:
// one block read per cycle through the size table's registered port, until a free
// block large enough is hit or min(block_count, NUM_BLOCKS) blocks are checked.
// Next beat accepted while the result shows; a held result holds the next check stage.
// Synchronous active-low reset: block_count 0, every block free, no result.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = ffba_pkg::DEF_SIZE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [ffba_pkg::INDEX_W-1:0]      i_block_index,
    input  logic [ffba_pkg::SIZE_FIELD_W-1:0] i_size_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [ffba_pkg::INDEX_W-1:0]      o_granted_block,
    output logic [ffba_pkg::SIZE_FIELD_W-1:0] o_fragment,
    input  logic                              i_cfg_we,
    input  logic [ffba_pkg::COUNT_W-1:0]      i_cfg_data
);

    ffba_pkg::t_ffba_ctl    ctl;
    ffba_pkg::t_ffba_status status;

    // Handshakes and scan sequence
    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl),
        .i_status    (status)
    );

    // Table, flags, check stage and result
    ffba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_block_index   (i_block_index),
        .i_size_value    (i_size_value),
        .o_found         (o_found),
        .o_granted_block (o_granted_block),
        .o_fragment      (o_fragment)
    );

endmodule

/* design/ffba_datapath.sv */
// Datapath of the first-fit block allocator: size table memory, used
// flags, scan pointer, check stage and result register. Uses ffba_pkg.
module ffba_datapath #(
    parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = ffba_pkg::DEF_SIZE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffba_pkg::t_ffba_ctl               i_ctl,
    output ffba_pkg::t_ffba_status            o_status,
    input  logic                              i_cfg_we,
    input  logic [ffba_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic [ffba_pkg::INDEX_W-1:0]      i_block_index,
    input  logic [ffba_pkg::SIZE_FIELD_W-1:0] i_size_value,
    output logic                              o_found,
    output logic [ffba_pkg::INDEX_W-1:0]      o_granted_block,
    output logic [ffba_pkg::SIZE_FIELD_W-1:0] o_fragment
);

    localparam int CW    = ffba_pkg::COUNT_W;
    localparam int XW    = ffba_pkg::INDEX_W;
    localparam int FW    = ffba_pkg::SIZE_FIELD_W;
    localparam int TRACK = (NUM_BLOCKS < ffba_pkg::MAX_SCAN) ? NUM_BLOCKS
                                                              : ffba_pkg::MAX_SCAN;
    localparam int AW    = $clog2(NUM_BLOCKS);
    localparam int IW    = $clog2(TRACK);
    localparam int PW    = $clog2(TRACK + 1);

    logic [CW-1:0]        r_block_count;
    logic [SIZE_BITS-1:0] r_mem [NUM_BLOCKS];
    logic [TRACK-1:0]     r_used;
    logic [PW-1:0]        r_ptr;
    logic [PW-1:0]        r_limit;
    logic [PW-1:0]        n_limit;
    logic [SIZE_BITS-1:0] r_req;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_rd_valid;
    logic                 r_found;
    logic [XW-1:0]        r_granted_block;
    logic [FW-1:0]        r_fragment;
    logic                 load_in_table;
    logic                 load_in_track;
    logic                 issue;

    // Scan limit saturates at the table depth
    assign n_limit = (32'(r_block_count) > NUM_BLOCKS) ? PW'(NUM_BLOCKS)
                                                        : PW'(r_block_count);

    assign load_in_table = (32'(i_block_index) < NUM_BLOCKS);
    assign load_in_track = (32'(i_block_index) < TRACK);
    assign issue         = i_ctl.scan && (r_ptr < r_limit);

    // Block count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            r_block_count <= i_cfg_data;
        end
    end

    // Size table: one write port for loads, one registered read for the scan
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && load_in_table) begin
            r_mem[AW'(i_block_index)] <= SIZE_BITS'(i_size_value);
        end
        if (issue) begin
            r_rd_data <= r_mem[AW'(r_ptr)];
        end
    end

    // Used flags: free on load, take on grant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_ctl.load && load_in_track) begin
                r_used[IW'(i_block_index)] <= 1'b0;
            end
            if (i_ctl.grant) begin
                r_used[r_rd_idx] <= 1'b1;
            end
        end
    end

    // Scan pointer and check-stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_rd_valid <= 1'b0;
        end else if (i_ctl.start) begin
            r_ptr      <= '0;
            r_rd_valid <= 1'b0;
        end else if (i_ctl.scan) begin
            r_rd_valid <= issue;
            if (issue) begin
                r_ptr <= r_ptr + PW'(1);
            end
        end
    end

    // Request, limit and check-stage index
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_req   <= SIZE_BITS'(i_size_value);
            r_limit <= n_limit;
        end
        if (issue) begin
            r_rd_idx <= IW'(r_ptr);
        end
    end

    // Check stage
    assign o_status.hit       = r_rd_valid && !r_used[r_rd_idx] && (r_rd_data >= r_req);
    assign o_status.exhausted = !r_rd_valid && (r_ptr == r_limit);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.grant) begin
            r_found         <= 1'b1;
            r_granted_block <= XW'(r_rd_idx);
            r_fragment      <= FW'(r_rd_data - r_req);
        end else if (i_ctl.miss) begin
            r_found         <= 1'b0;
            r_granted_block <= '0;
            r_fragment      <= '0;
        end
    end

    assign o_found         = r_found;
    assign o_granted_block = r_granted_block;
    assign o_fragment      = r_fragment;

endmodule

/* design/ffba_ctrl.sv */
// Controller of the first-fit block allocator: input and output
// handshakes and the scan sequence. Uses ffba_pkg.
module ffba_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_cmd,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output ffba_pkg::t_ffba_ctl    o_ctl,
    input  ffba_pkg::t_ffba_status i_status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;
    logic resolve;
    logic finish;

    assign out_free = !r_out_valid || i_out_ready;
    assign resolve  = i_status.hit || i_status.exhausted;

    // Sequence: take items in idle, scan until a hit or the limit
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_ctl       = '0;
        finish      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == ffba_pkg::CMD_LOAD) begin
                        o_ctl.load = 1'b1;
                    end else begin
                        o_ctl.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (resolve) begin
                    // hold the check stage until the result register frees
                    if (out_free) begin
                        o_ctl.grant = i_status.hit;
                        o_ctl.miss  = !i_status.hit;
                        finish      = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    o_ctl.scan = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/ffba_checker.sv */
// Port-level checker for the first-fit block allocator, bound to the top.
// Uses ffba_pkg and the macros of first_fit_block_allocator_defines.svh.
`include "first_fit_block_allocator_defines.svh"

module ffba_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_cmd,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_found,
    input logic [ffba_pkg::INDEX_W-1:0]      o_granted_block,
    input logic [ffba_pkg::SIZE_FIELD_W-1:0] o_fragment
);

    logic                                            alloc_beat;
    logic                                            out_stall;
    logic                                            miss_shown;
    logic                                            miss_clean;
    logic [ffba_pkg::INDEX_W+ffba_pkg::SIZE_FIELD_W:0] result_bits;

    assign alloc_beat  = i_in_valid && o_in_ready && (i_cmd == ffba_pkg::CMD_ALLOC);
    assign out_stall   = o_out_valid && !i_out_ready;
    assign miss_shown  = o_out_valid && !o_found;
    assign miss_clean  = (o_granted_block == '0) && (o_fragment == '0);
    assign result_bits = {o_found, o_granted_block, o_fragment};

    // A stalled result holds
    `FFBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(result_bits))

    // A miss reports zero block and zero fragment
    `FFBA_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, miss_shown, miss_clean)

    // An allocate beat blocks input while its scan runs
    `FFBA_ASSERT_NEXT(a_alloc_busy, i_clk, i_rst_n, alloc_beat, !o_in_ready)

    // A fresh result comes with the input side open again
    `FFBA_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, $rose(o_out_valid), o_in_ready)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
